FILE: rtl/bbca_pkg.sv
// Package for the clipped box blur: sizes, register indexes, request codes
// and the structs passed between the front end, the job queue and the back end.
// No dependencies.
`timescale 1ns / 1ps
package bbca_pkg;

  localparam int MAX_SIDE    = 1024;
  localparam int MAX_KERNEL  = 15;
  localparam int SAMPLE_BITS = 16;

  localparam int STORE_ROWS  = MAX_KERNEL + 1;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int POS_W       = $clog2(MAX_SIDE);
  localparam int KER_W       = $clog2(MAX_KERNEL + 1);
  localparam int SLOT_W      = $clog2(STORE_ROWS);
  localparam int STORE_DEPTH = STORE_ROWS * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths of the channels
  localparam int HEIGHT_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int MAP_REG_W   = 11;
  localparam int KER_REG_W   = 4;

  localparam int RESET_SIDE   = 256;
  localparam int RESET_KERNEL = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_SIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIDE = 2'd1;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic [KER_W-1:0]  kernel;
  } cfg_t;

  // One output pixel to compute
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/bbca_if.sv
// Channel interfaces of the clipped box blur: sample input, result output,
// configuration write. Depends on bbca_pkg.
`timescale 1ns / 1ps
interface bbca_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bbca_pkg::HEIGHT_W-1:0] height_in;
  modport source (output valid, req_type, height_in, input ready);
  modport sink   (input valid, req_type, height_in, output ready);
endinterface

interface bbca_result_if;
  logic                          valid;
  logic                          ready;
  logic [bbca_pkg::HEIGHT_W-1:0] height_out;
  logic                          frame_last;
  modport source (output valid, height_out, frame_last, input ready);
  modport sink   (input valid, height_out, frame_last, output ready);
endinterface

interface bbca_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bbca_pkg::CFG_IDX_W-1:0]  index;
  logic [bbca_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bbca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bbca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bbca_queue.sv
// Short job queue between the front end and the back end.
// Depends on bbca_pkg.
`timescale 1ns / 1ps
module bbca_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bbca_pkg::job_t      push_job,
  input  logic                pop,
  output bbca_pkg::job_t      head,
  output bbca_pkg::q_status_t status
);

  bbca_pkg::job_t                  slots [bbca_pkg::QUEUE_DEPTH];
  logic [bbca_pkg::QPTR_W-1:0]     wptr;
  logic [bbca_pkg::QPTR_W-1:0]     rptr;
  logic [bbca_pkg::QCNT_W-1:0]     fill;

  assign head         = slots[rptr];
  assign status.full  = (fill == bbca_pkg::QCNT_W'(bbca_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == bbca_pkg::QPTR_W'(bbca_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == bbca_pkg::QPTR_W'(bbca_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push || pop)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("job popped from empty queue");

endmodule

FILE: rtl/bbca_front.sv
// Front end of the clipped box blur: configuration registers, input raster
// position, row store writes and issue of output jobs. Depends on bbca_pkg, bbca_if.
`timescale 1ns / 1ps
module bbca_front (
  input  logic                        clk,
  input  logic                        rst,
  bbca_sample_if.sink                 sample_ch,
  bbca_cfg_if.sink                    cfg_ch,
  output bbca_pkg::cfg_t              cfg,
  output logic                        st_we,
  output logic [bbca_pkg::ADDR_W-1:0] st_waddr,
  output logic [bbca_pkg::SAMPLE_BITS-1:0] st_wdata,
  output logic                        push,
  output bbca_pkg::job_t              push_job,
  input  bbca_pkg::q_status_t         q_status,
  input  logic                        back_idle
);

  logic [bbca_pkg::MAP_REG_W-1:0] map_side;
  logic [bbca_pkg::KER_REG_W-1:0] kernel_side;
  logic [bbca_pkg::POS_W-1:0]     in_col;
  logic [bbca_pkg::POS_W-1:0]     in_row;
  logic [bbca_pkg::SLOT_W-1:0]    in_slot;
  logic [bbca_pkg::POS_W-1:0]     out_col;
  logic [bbca_pkg::POS_W-1:0]     out_row;
  logic [bbca_pkg::SLOT_W-1:0]    out_slot;
  logic                           frame_done;
  logic                           wrap_wait;

  logic [bbca_pkg::SIDE_W-1:0]    side;
  logic [bbca_pkg::SIDE_W-1:0]    side_m1;
  logic [bbca_pkg::KER_W-1:0]     kernel;
  logic [bbca_pkg::SIDE_W-1:0]    down;
  logic                           take;
  logic                           is_sample;
  logic                           in_end;
  logic                           in_row_end;
  logic                           out_row_end;
  logic                           out_last;
  logic                           reached;
  logic                           cfg_take;

  // Clamp the configuration
  always_comb begin
    if (map_side < bbca_pkg::MAP_REG_W'(2)) begin
      side = bbca_pkg::SIDE_W'(2);
    end else if (32'(map_side) > bbca_pkg::MAX_SIDE) begin
      side = bbca_pkg::SIDE_W'(bbca_pkg::MAX_SIDE);
    end else begin
      side = bbca_pkg::SIDE_W'(map_side);
    end
    if (kernel_side == '0) begin
      kernel = bbca_pkg::KER_W'(1);
    end else if (32'(kernel_side) > bbca_pkg::MAX_KERNEL) begin
      kernel = bbca_pkg::KER_W'(bbca_pkg::MAX_KERNEL);
    end else begin
      kernel = bbca_pkg::KER_W'(kernel_side);
    end
  end

  assign cfg.side   = side;
  assign cfg.kernel = kernel;
  assign side_m1    = side - 1'b1;
  assign down       = bbca_pkg::SIDE_W'(kernel - 1'b1 - (kernel >> 1));

  // Classify the request
  assign take        = sample_ch.valid && sample_ch.ready;
  assign is_sample   = (sample_ch.req_type == bbca_pkg::REQ_SAMPLE);
  assign in_row_end  = (bbca_pkg::SIDE_W'(in_col) == side_m1);
  assign in_end      = in_row_end && (bbca_pkg::SIDE_W'(in_row) == side_m1);
  assign out_row_end = (bbca_pkg::SIDE_W'(out_col) == side_m1);
  assign out_last    = out_row_end && (bbca_pkg::SIDE_W'(out_row) == side_m1);
  assign reached     = (bbca_pkg::SIDE_W'(in_row) > down) ||
                       ((bbca_pkg::SIDE_W'(in_row) == down) &&
                        (bbca_pkg::SIDE_W'(in_col) >= down));

  assign sample_ch.ready = !q_status.full && !wrap_wait;
  assign cfg_ch.ready    = 1'b1;
  assign cfg_take        = cfg_ch.valid && cfg_ch.ready;

  assign st_we    = take && is_sample && !frame_done;
  assign st_waddr = bbca_pkg::ADDR_W'(32'(in_slot) * bbca_pkg::MAX_SIDE + 32'(in_col));
  assign st_wdata = bbca_pkg::SAMPLE_BITS'(sample_ch.height_in);

  assign push = take && ((is_sample && !frame_done && reached) ||
                         (!is_sample && frame_done));
  assign push_job.row  = out_row;
  assign push_job.col  = out_col;
  assign push_job.slot = out_slot;
  assign push_job.last = out_last;

  // Hold new requests after a frame's last job until the queue is empty and the back end is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_wait <= 1'b0;
    end else if (push && out_last) begin
      wrap_wait <= 1'b1;
    end else if (q_status.empty && back_idle) begin
      wrap_wait <= 1'b0;
    end
  end

  // Track input and output raster positions
  always_ff @(posedge clk) begin
    if (rst) begin
      map_side    <= bbca_pkg::MAP_REG_W'(bbca_pkg::RESET_SIDE);
      kernel_side <= bbca_pkg::KER_REG_W'(bbca_pkg::RESET_KERNEL);
      in_col      <= '0;
      in_row      <= '0;
      in_slot     <= '0;
      out_col     <= '0;
      out_row     <= '0;
      out_slot    <= '0;
      frame_done  <= 1'b0;
    end else if (cfg_take) begin
      if (cfg_ch.index == bbca_pkg::REG_MAP_SIDE) begin
        map_side <= cfg_ch.data[bbca_pkg::MAP_REG_W-1:0];
      end
      if (cfg_ch.index == bbca_pkg::REG_KERNEL_SIDE) begin
        kernel_side <= cfg_ch.data[bbca_pkg::KER_REG_W-1:0];
      end
      if (cfg_ch.index == bbca_pkg::REG_MAP_SIDE ||
          cfg_ch.index == bbca_pkg::REG_KERNEL_SIDE) begin
        in_col     <= '0;
        in_row     <= '0;
        in_slot    <= '0;
        out_col    <= '0;
        out_row    <= '0;
        out_slot   <= '0;
        frame_done <= 1'b0;
      end
    end else begin
      // The frame restart below covers a last sample that also ends the frame
      if (st_we && !(push && out_last)) begin
        if (in_end) begin
          frame_done <= 1'b1;
        end else if (in_row_end) begin
          in_col  <= '0;
          in_row  <= in_row + 1'b1;
          in_slot <= (in_slot == bbca_pkg::SLOT_W'(bbca_pkg::STORE_ROWS - 1)) ?
                     '0 : in_slot + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (push) begin
        if (out_last) begin
          in_col     <= '0;
          in_row     <= '0;
          in_slot    <= '0;
          out_col    <= '0;
          out_row    <= '0;
          out_slot   <= '0;
          frame_done <= 1'b0;
        end else if (out_row_end) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (out_slot == bbca_pkg::SLOT_W'(bbca_pkg::STORE_ROWS - 1)) ?
                      '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/bbca_back.sv
// Back end of the clipped box blur: scans the clipped window from the row
// store, divides the sum by the pixel count, holds the result. Depends on bbca_pkg, bbca_if.
`timescale 1ns / 1ps
module bbca_back (
  input  logic                        clk,
  input  logic                        rst,
  input  bbca_pkg::cfg_t              cfg,
  input  bbca_pkg::job_t              head,
  input  bbca_pkg::q_status_t         q_status,
  output logic                        pop,
  output logic                        idle,
  output logic [bbca_pkg::ADDR_W-1:0] st_raddr,
  input  logic [bbca_pkg::SAMPLE_BITS-1:0] st_rdata,
  bbca_result_if.source               result_ch
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_FLUSH  = 6'b001000,
    S_DIVIDE = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  localparam int SW = bbca_pkg::SIDE_W + 2;

  state_t                          state;
  state_t                          state_next;
  bbca_pkg::job_t                  job;
  logic [bbca_pkg::POS_W-1:0]      x;
  logic [bbca_pkg::POS_W-1:0]      y;
  logic [bbca_pkg::SLOT_W-1:0]     yslot;
  logic [bbca_pkg::POS_W-1:0]      c0;
  logic [bbca_pkg::POS_W-1:0]      c1;
  logic [bbca_pkg::POS_W-1:0]      r1;
  logic                            rd_pend;
  logic [bbca_pkg::SUM_W-1:0]      sum;
  logic [bbca_pkg::CNT_W-1:0]      cnt;
  logic [bbca_pkg::CNT_W-1:0]      rem;
  logic [bbca_pkg::STEP_W-1:0]     step;
  logic                            ovalid;
  logic [bbca_pkg::HEIGHT_W-1:0]   oheight;
  logic                            olast;
  logic                            out_load;

  logic signed [SW-1:0] half_s;
  logic signed [SW-1:0] kern_s;
  logic signed [SW-1:0] smax_s;
  logic signed [SW-1:0] rs;
  logic signed [SW-1:0] re;
  logic signed [SW-1:0] cs;
  logic signed [SW-1:0] ce;
  logic [bbca_pkg::POS_W-1:0]  r0_w;
  logic [bbca_pkg::POS_W-1:0]  r1_w;
  logic [bbca_pkg::POS_W-1:0]  c0_w;
  logic [bbca_pkg::POS_W-1:0]  c1_w;
  logic [bbca_pkg::SLOT_W:0]   back_rows;
  logic [bbca_pkg::SLOT_W:0]   slot0;
  logic [bbca_pkg::CNT_W:0]    rem_sh;
  logic                        ge;

  // Clip the window of the held job
  always_comb begin
    half_s = SW'(cfg.kernel >> 1);
    kern_s = SW'(cfg.kernel);
    smax_s = SW'(cfg.side) - SW'(1);
    rs = SW'(job.row) - half_s;
    re = rs + kern_s - SW'(1);
    cs = SW'(job.col) - half_s;
    ce = cs + kern_s - SW'(1);
    r0_w = (rs < 0) ? '0 : bbca_pkg::POS_W'(rs);
    c0_w = (cs < 0) ? '0 : bbca_pkg::POS_W'(cs);
    r1_w = (re > smax_s) ? bbca_pkg::POS_W'(smax_s) : bbca_pkg::POS_W'(re);
    c1_w = (ce > smax_s) ? bbca_pkg::POS_W'(smax_s) : bbca_pkg::POS_W'(ce);
    back_rows = (bbca_pkg::SLOT_W + 1)'(job.row - r0_w);
    if ({1'b0, job.slot} >= back_rows) begin
      slot0 = {1'b0, job.slot} - back_rows;
    end else begin
      slot0 = {1'b0, job.slot} + (bbca_pkg::SLOT_W + 1)'(bbca_pkg::STORE_ROWS) - back_rows;
    end
  end

  // One restoring division step
  assign rem_sh = {rem, sum[bbca_pkg::SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, cnt});

  assign pop      = (state == S_IDLE) && !q_status.empty;
  assign idle     = (state == S_IDLE);
  assign out_load = (state == S_EMIT) && (!ovalid || result_ch.ready);
  assign st_raddr = bbca_pkg::ADDR_W'(32'(yslot) * bbca_pkg::MAX_SIDE + 32'(x));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (!q_status.empty) state_next = S_SETUP;
      S_SETUP:  state_next = S_SCAN;
      S_SCAN:   if (x == c1 && y == r1) state_next = S_FLUSH;
      S_FLUSH:  state_next = S_DIVIDE;
      S_DIVIDE: if (step == bbca_pkg::STEP_W'(bbca_pkg::SUM_W - 1)) state_next = S_EMIT;
      S_EMIT:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_SCAN);
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (result_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Scan, accumulate and divide
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    case (state)
      S_SETUP: begin
        x     <= c0_w;
        y     <= r0_w;
        yslot <= bbca_pkg::SLOT_W'(slot0);
        c0    <= c0_w;
        c1    <= c1_w;
        r1    <= r1_w;
        sum   <= '0;
        cnt   <= '0;
        rem   <= '0;
        step  <= '0;
      end
      S_SCAN: begin
        cnt <= cnt + 1'b1;
        if (x == c1) begin
          x <= c0;
          if (y != r1) begin
            y     <= y + 1'b1;
            yslot <= (yslot == bbca_pkg::SLOT_W'(bbca_pkg::STORE_ROWS - 1)) ?
                     '0 : yslot + 1'b1;
          end
        end else begin
          x <= x + 1'b1;
        end
      end
      S_DIVIDE: begin
        sum  <= {sum[bbca_pkg::SUM_W-2:0], ge};
        rem  <= ge ? bbca_pkg::CNT_W'(rem_sh - {1'b0, cnt}) : bbca_pkg::CNT_W'(rem_sh);
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
    if (rd_pend) begin
      sum <= sum + bbca_pkg::SUM_W'(st_rdata);
    end
    if (out_load) begin
      oheight <= bbca_pkg::HEIGHT_W'(sum);
      olast   <= job.last;
    end
  end

  assign result_ch.valid      = ovalid;
  assign result_ch.height_out = oheight;
  assign result_ch.frame_last = olast;

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (cnt != '0))
    else $error("division by empty window");

  a_scan_ends_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> $past(state) == S_SCAN && rd_pend)
    else $error("flush without pending read");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state) == S_EMIT)
    else $error("result raised outside emit");

endmodule

FILE: rtl/box_blur_clipped_average.sv
// Top level of the clipped box blur: front end, job queue, row store, back end.
// Depends on bbca_pkg, bbca_if, bbca_ram, bbca_queue, bbca_front, bbca_back.
//
// Use: samples (req_type = sample) enter on sample_ch in raster order, one
// square frame of map_side x map_side pixels. Each output pixel is the mean of
// the kernel window clipped to the map, issued on result_ch as soon as its
// window is in; the outputs still owed after the last sample come out one per
// drain request. frame_last marks the final pixel of a frame.
// cfg_ch writes map_side (index 0) or kernel_side (index 1) and restarts the
// frame; write it only while the block is idle. cfg_ch is always ready.
// Throughput: the back end handles one output at a time; each output passes
// through pop, setup, a scan of the clipped window (one row store read per
// cycle), flush, a 24-step restoring divider and emit.
// The front end takes one request per cycle while the two-entry job queue
// has room, so samples that cause no output pass at one per cycle. After the
// last output job of a frame sample_ch holds ready low until the back end idles.
// Reset: map_side 256, kernel_side 3, positions cleared; row store contents
// are not cleared. When result_ch stalls the result is held, the queue fills
// and sample_ch drops ready.
`timescale 1ns / 1ps
module box_blur_clipped_average (
  input  logic          clk,
  input  logic          rst,
  bbca_sample_if.sink   sample_ch,
  bbca_cfg_if.sink      cfg_ch,
  bbca_result_if.source result_ch
);

  bbca_pkg::cfg_t                   cfg;
  logic                             st_we;
  logic [bbca_pkg::ADDR_W-1:0]      st_waddr;
  logic [bbca_pkg::SAMPLE_BITS-1:0] st_wdata;
  logic [bbca_pkg::ADDR_W-1:0]      st_raddr;
  logic [bbca_pkg::SAMPLE_BITS-1:0] st_rdata;
  logic                             push;
  logic                             pop;
  logic                             back_idle;
  bbca_pkg::job_t                   push_job;
  bbca_pkg::job_t                   head;
  bbca_pkg::q_status_t              q_status;

  bbca_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_ch),
    .cfg_ch   (cfg_ch),
    .cfg      (cfg),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .push     (push),
    .push_job (push_job),
    .q_status (q_status),
    .back_idle(back_idle)
  );

  bbca_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  bbca_ram #(
    .WIDTH(bbca_pkg::SAMPLE_BITS),
    .DEPTH(bbca_pkg::STORE_DEPTH)
  ) u_row_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  bbca_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .idle     (back_idle),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .result_ch(result_ch)
  );

endmodule

FILE: test/tb_box_blur_clipped_average.sv
// Regression bench for the clipped box blur: streams height maps through
// u_top and checks every window mean against a cycle-free predictor.
// Depends on bbca_pkg, bbca_if and the box_blur_clipped_average RTL.
`timescale 1ns / 1ps
module tb_box_blur_clipped_average;

  localparam int SETTLE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [bbca_pkg::HEIGHT_W-1:0] height;
    logic                          last;
  } mean_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbca_sample_if sample_ch();
  bbca_cfg_if    cfg_ch();
  bbca_result_if result_ch();

  box_blur_clipped_average u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .cfg_ch    (cfg_ch),
    .result_ch (result_ch)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [bbca_pkg::HEIGHT_W-1:0]  line_rows [bbca_pkg::STORE_ROWS*bbca_pkg::MAX_SIDE];
  logic [bbca_pkg::MAP_REG_W-1:0] side_reg;
  logic [bbca_pkg::KER_REG_W-1:0] kernel_reg;
  int                             in_col, in_row, out_col, out_row;
  bit                             frame_full;

  mean_t pending_means[$];
  int    mismatch_count = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    recv_hold = 0;
  bit    hold_trigger = 1'b0;
  bit    hold_done = 1'b0;
  int    quiet_cycles = 0;

  function automatic int clamped_side();
    if (side_reg < 2) return 2;
    if (side_reg > bbca_pkg::MAX_SIDE) return bbca_pkg::MAX_SIDE;
    return side_reg;
  endfunction

  function automatic int clamped_kernel();
    if (kernel_reg < 1) return 1;
    if (kernel_reg > bbca_pkg::MAX_KERNEL) return bbca_pkg::MAX_KERNEL;
    return kernel_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_full = 0;
  endfunction

  // Mean of the window around the next output pixel, clipped to the map
  function automatic mean_t window_mean();
    int    s, k, r0, r1, c0, c1, cnt;
    longint sum;
    mean_t m;
    s = clamped_side();
    k = clamped_kernel();
    r0 = out_row - k / 2;
    c0 = out_col - k / 2;
    r1 = r0 + k - 1;
    c1 = c0 + k - 1;
    if (r0 < 0) r0 = 0;
    if (c0 < 0) c0 = 0;
    if (r1 > s - 1) r1 = s - 1;
    if (c1 > s - 1) c1 = s - 1;
    sum = 0;
    cnt = 0;
    for (int y = r0; y <= r1; y++) begin
      for (int x = c0; x <= c1; x++) begin
        sum += line_rows[(y % bbca_pkg::STORE_ROWS) * bbca_pkg::MAX_SIDE + x];
        cnt++;
      end
    end
    m.height = (cnt != 0) ? bbca_pkg::HEIGHT_W'(sum / cnt) : '0;
    m.last = (out_row == s - 1) && (out_col == s - 1);
    if (m.last) begin
      restart_frame();
    end else if (++out_col >= s) begin
      out_col = 0;
      out_row++;
    end
    return m;
  endfunction

  // Advance the predictor by one accepted request; queue any mean it owes
  function automatic void predict_request(logic kind, logic [bbca_pkg::HEIGHT_W-1:0] h);
    int s, k, down, lag, pos;
    s = clamped_side();
    k = clamped_kernel();
    down = k - 1 - k / 2;
    lag = down * s + down;
    if (kind == bbca_pkg::REQ_DRAIN) begin
      if (frame_full) pending_means.push_back(window_mean());
      return;
    end
    if (frame_full) return;
    line_rows[(in_row % bbca_pkg::STORE_ROWS) * bbca_pkg::MAX_SIDE + in_col] = h;
    pos = in_row * s + in_col;
    if (pos == s * s - 1) begin
      frame_full = 1;
    end else if (++in_col >= s) begin
      in_col = 0;
      in_row++;
    end
    if (pos >= lag) pending_means.push_back(window_mean());
  endfunction

  function automatic void predict_config(logic [bbca_pkg::CFG_IDX_W-1:0] idx,
                                         logic [bbca_pkg::CFG_DATA_W-1:0] val);
    if (idx == bbca_pkg::REG_MAP_SIDE) begin
      side_reg = val[bbca_pkg::MAP_REG_W-1:0];
      restart_frame();
    end else if (idx == bbca_pkg::REG_KERNEL_SIDE) begin
      kernel_reg = val[bbca_pkg::KER_REG_W-1:0];
      restart_frame();
    end
  endfunction

  // Offer one request, with random idle cycles first; keep valid high after
  task automatic send_request(logic kind, logic [bbca_pkg::HEIGHT_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.req_type <= kind;
    sample_ch.height_in <= h;
    do @(posedge clk); while (!sample_ch.ready);
    predict_request(kind, h);
  endtask

  task automatic send_sample(logic [bbca_pkg::HEIGHT_W-1:0] h);
    send_request(bbca_pkg::REQ_SAMPLE, h);
  endtask

  task automatic send_drain();
    send_request(bbca_pkg::REQ_DRAIN, bbca_pkg::HEIGHT_W'($urandom_range(16'hFFFF)));
  endtask

  // Wait for all owed means, let the back end finish, drop the sample valid
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bbca_pkg::CFG_IDX_W-1:0] idx,
                           logic [bbca_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    predict_config(idx, val);
  endtask

  task automatic drain_frame(int extra);
    while (frame_full) send_drain();
    repeat (extra) send_drain();
  endtask

  function automatic logic [bbca_pkg::HEIGHT_W-1:0] random_height();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return bbca_pkg::HEIGHT_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Reset registers in place: a partial frame at 256 x 256, kernel 3
  task automatic test_reset_defaults();
    for (int i = 0; i < 20; i++) send_sample(random_height());
  endtask

  // Clamping, extremes, ignored requests and the frame wrap
  task automatic test_directed();
    write_reg(bbca_pkg::REG_MAP_SIDE, 11'd0);
    write_reg(bbca_pkg::REG_KERNEL_SIDE, 11'd0);
    send_drain();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_drain();
    write_reg(bbca_pkg::REG_MAP_SIDE, 11'd3);
    write_reg(bbca_pkg::REG_KERNEL_SIDE, 11'd3);
    for (int i = 0; i < 9; i++) send_sample(i[0] ? 16'hFFFF : 16'h0000);
    send_sample(16'h1234);
    drain_frame(1);
    write_reg(bbca_pkg::REG_KERNEL_SIDE, 11'd15);
    write_reg(2'd2, 11'h7FF);
    write_reg(2'd3, 11'h000);
    write_reg(bbca_pkg::REG_MAP_SIDE, 11'd1);
    for (int i = 0; i < 4; i++) send_sample(16'hFFFF);
    drain_frame(0);
  endtask

  // Widest map: oversize and exact-maximum sides, past one full row
  task automatic test_wide_map();
    write_reg(bbca_pkg::REG_MAP_SIDE, 11'h7FF);
    write_reg(bbca_pkg::REG_KERNEL_SIDE, 11'd1);
    for (int i = 0; i < 40; i++) send_sample(random_height());
    write_reg(bbca_pkg::REG_MAP_SIDE, 11'd1025);
    write_reg(bbca_pkg::REG_KERNEL_SIDE, 11'd2);
    for (int i = 0; i < bbca_pkg::MAX_SIDE + 8; i++) send_sample(random_height());
    write_reg(bbca_pkg::REG_MAP_SIDE, bbca_pkg::CFG_DATA_W'(bbca_pkg::MAX_SIDE));
    for (int i = 0; i < 8; i++) send_sample(16'hFFFF);
  endtask

  // Random frames: mostly whole frames with random content, some noise
  task automatic test_random_frames(int target);
    int sent, s, phase;
    bit squeezed;
    sent = 0;
    squeezed = 0;
    while (sent < target) begin
      phase = sent * 3 / target;
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 9 : 0;
      s = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 2);
      write_reg(bbca_pkg::REG_MAP_SIDE, bbca_pkg::CFG_DATA_W'(s));
      write_reg(bbca_pkg::REG_KERNEL_SIDE, bbca_pkg::CFG_DATA_W'($urandom_range(15)));
      if (!squeezed && sent > target / 2) begin
        hold_trigger = 1'b1;
        squeezed = 1;
      end
      for (int i = 0; i < s * s; i++) begin
        if ($urandom_range(99) < 3) send_drain();
        if ($urandom_range(199) == 0) break;
        send_sample(random_height());
        sent++;
      end
      if (frame_full && $urandom_range(3) == 0) send_sample(random_height());
      if (frame_full) drain_frame($urandom_range(2));
      sent += 2;
    end
  endtask

  // Result port: random back-pressure, long hold on request, check each mean
  always @(posedge clk) begin
    mean_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected result height_out=%h frame_last=%b",
               result_ch.height_out, result_ch.frame_last);
        mismatch_count++;
      end else begin
        want = pending_means.pop_front();
        if (result_ch.height_out !== want.height) begin
          $error("height_out expected %h actual %h", want.height, result_ch.height_out);
          mismatch_count++;
        end
        if (result_ch.frame_last !== want.last) begin
          $error("frame_last expected %b actual %b", want.last, result_ch.frame_last);
          mismatch_count++;
        end
      end
    end
    if (hold_trigger && !hold_done) begin
      hold_done <= 1'b1;
      recv_hold <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no request, result or write accepted
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("box_blur_clipped_average regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.req_type = bbca_pkg::REQ_SAMPLE;
    sample_ch.height_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bbca_pkg::REG_MAP_SIDE;
    cfg_ch.data = '0;
    foreach (line_rows[i]) line_rows[i] = '0;
    side_reg = bbca_pkg::MAP_REG_W'(bbca_pkg::RESET_SIDE);
    kernel_reg = bbca_pkg::KER_REG_W'(bbca_pkg::RESET_KERNEL);
    restart_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_wide_map();
    test_random_frames(900);
    settle();
    if (mismatch_count == 0) begin
      $display("box_blur_clipped_average regression: pass");
    end else begin
      $display("box_blur_clipped_average regression: fail");
    end
    $finish;
  end

endmodule
